// ===== hdl/ptrf_pkg.sv =====
// shared types and constants for the peer table replay filter
// no dependencies; used by every module under hdl
package ptrf_pkg;

   // table geometry
   localparam int NUM_SLOTS  = 16;
   localparam int RESULT_CAP = 16;
   localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W      = $clog2(RESULT_CAP + 1);

   // field widths
   localparam int ACTION_W = 2;
   localparam int ADDR_W   = 48;
   localparam int SEQ_W    = 32;
   localparam int ACCEL_W  = 16;
   localparam int TIME_W   = 32;
   localparam int MOTION_W = 3;

   // control register port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_DATA_W-1:0] TIMEOUT_RST = 32'd2000;
   localparam logic [CSR_DATA_W-1:0] REBOOT_RST  = 32'd1000;

   // front queue
   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   typedef enum logic [ACTION_W-1:0] {
      OP_UPDATE   = 2'd0,
      OP_MOTION   = 2'd1,
      OP_SNAPSHOT = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIMEOUT = 1'b0,
      CSR_REBOOT  = 1'b1
   } csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVAL,
      ST_COMMIT,
      ST_MOTION,
      ST_CLEAR,
      ST_RESULT,
      ST_SNAP,
      ST_SNAP_END
   } back_state_type;

   // one queued input word
   typedef struct packed {
      op_type                     op;
      logic [ADDR_W-1:0]          addr;
      logic [SEQ_W-1:0]           seq;
      logic signed [ACCEL_W-1:0]  accel;
      logic [TIME_W-1:0]          now;
      logic [MOTION_W-1:0]        motion;
   } item_type;

   // one table entry
   typedef struct packed {
      logic                       used;
      logic [ADDR_W-1:0]          addr;
      logic [SEQ_W-1:0]           seq;
      logic signed [ACCEL_W-1:0]  accel;
      logic [TIME_W-1:0]          rx_time;
      logic [MOTION_W-1:0]        motion;
   } slot_type;

   // table write and clear command
   typedef struct packed {
      logic              we;
      logic              clr;
      logic [SLOT_W-1:0] idx;
      slot_type          data;
   } tbl_wr_type;

   // one result word
   typedef struct packed {
      logic                       accepted;
      logic                       found;
      logic                       entry_valid;
      logic [ADDR_W-1:0]          peer_addr;
      logic [SEQ_W-1:0]           peer_seq;
      logic signed [ACCEL_W-1:0]  peer_accel;
      logic [TIME_W-1:0]          peer_rx_time;
      logic [MOTION_W-1:0]        peer_motion;
      logic                       last;
   } rsp_type;

endpackage

// ===== hdl/ptrf_front.sv =====
// front end: accepts request words, decodes the action, queues them
// depends on ptrf_pkg
module ptrf_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ptrf_pkg::ACTION_W-1:0]     req_action,
   input  logic [ptrf_pkg::ADDR_W-1:0]       req_station_addr,
   input  logic [ptrf_pkg::SEQ_W-1:0]        req_seq_num,
   input  logic signed [ptrf_pkg::ACCEL_W-1:0] req_accel_value,
   input  logic [ptrf_pkg::TIME_W-1:0]       req_now_time,
   input  logic [ptrf_pkg::MOTION_W-1:0]     req_motion_code,
   output logic                              head_valid,
   output ptrf_pkg::item_type                head_item,
   input  logic                              head_pop
);

   ptrf_pkg::item_type q_ff [ptrf_pkg::QDEPTH];
   logic [ptrf_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ptrf_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ptrf_pkg::QCNT_W-1:0] cnt_ff, cnt_in;
   logic                        push;
   logic                        pop;
   ptrf_pkg::item_type          new_item;

   // decode the incoming word
   always_comb begin
      new_item.op     = ptrf_pkg::op_type'(req_action);
      new_item.addr   = req_station_addr;
      new_item.seq    = req_seq_num;
      new_item.accel  = req_accel_value;
      new_item.now    = req_now_time;
      new_item.motion = req_motion_code;
   end

   assign req_ready  = (cnt_ff != ptrf_pkg::QCNT_W'(ptrf_pkg::QDEPTH));
   assign push       = req_valid && req_ready;
   assign head_valid = (cnt_ff != '0);
   assign pop        = head_pop && head_valid;
   assign head_item  = q_ff[rd_ptr_ff];

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== hdl/ptrf_table.sv =====
// peer table storage: per-slot registers, one read port, one write port
// depends on ptrf_pkg
module ptrf_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ptrf_pkg::SLOT_W-1:0]   rd_idx,
   output ptrf_pkg::slot_type            rd_slot,
   input  ptrf_pkg::tbl_wr_type          wr
);

   logic [ptrf_pkg::NUM_SLOTS-1:0] used_ff;
   logic [ptrf_pkg::ADDR_W-1:0]          addr_ff   [ptrf_pkg::NUM_SLOTS];
   logic [ptrf_pkg::SEQ_W-1:0]           seq_ff    [ptrf_pkg::NUM_SLOTS];
   logic signed [ptrf_pkg::ACCEL_W-1:0]  accel_ff  [ptrf_pkg::NUM_SLOTS];
   logic [ptrf_pkg::TIME_W-1:0]          rx_ff     [ptrf_pkg::NUM_SLOTS];
   logic [ptrf_pkg::MOTION_W-1:0]        motion_ff [ptrf_pkg::NUM_SLOTS];

   // used bits, cleared at reset and by the clear action
   always_ff @(posedge clock) begin
      if (reset || wr.clr) begin
         used_ff <= '0;
      end else if (wr.we) begin
         used_ff[wr.idx] <= wr.data.used;
      end
   end

   // entry contents, only meaningful while used
   always_ff @(posedge clock) begin
      if (wr.we) begin
         addr_ff[wr.idx]   <= wr.data.addr;
         seq_ff[wr.idx]    <= wr.data.seq;
         accel_ff[wr.idx]  <= wr.data.accel;
         rx_ff[wr.idx]     <= wr.data.rx_time;
         motion_ff[wr.idx] <= wr.data.motion;
      end
   end

   // read port
   always_comb begin
      rd_slot.used    = used_ff[rd_idx];
      rd_slot.addr    = addr_ff[rd_idx];
      rd_slot.seq     = seq_ff[rd_idx];
      rd_slot.accel   = accel_ff[rd_idx];
      rd_slot.rx_time = rx_ff[rd_idx];
      rd_slot.motion  = motion_ff[rd_idx];
   end

endmodule

// ===== hdl/ptrf_back.sv =====
// back end: walks the table for each queued word, updates it, drives results
// depends on ptrf_pkg; drives ptrf_table through its read and write ports
module ptrf_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  ptrf_pkg::item_type                head_item,
   output logic                              head_pop,
   output logic [ptrf_pkg::SLOT_W-1:0]       rd_idx,
   input  ptrf_pkg::slot_type                rd_slot,
   output ptrf_pkg::tbl_wr_type              tbl_wr,
   input  logic                              csr_valid,
   input  logic [ptrf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ptrf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ptrf_pkg::rsp_type                 rsp
);

   ptrf_pkg::back_state_type state_ff, state_in;
   ptrf_pkg::item_type       item_ff, item_in;
   logic [ptrf_pkg::SLOT_W-1:0] idx_ff, idx_in;
   logic                        match_ok_ff, match_ok_in;
   logic [ptrf_pkg::SLOT_W-1:0] match_idx_ff, match_idx_in;
   logic                        free_ok_ff, free_ok_in;
   logic [ptrf_pkg::SLOT_W-1:0] free_idx_ff, free_idx_in;
   logic [ptrf_pkg::TIME_W-1:0] worst_ff, worst_in;
   logic [ptrf_pkg::SLOT_W-1:0] pick_ff, pick_in;
   logic [ptrf_pkg::SLOT_W-1:0] tgt_ff, tgt_in;
   logic                        fresh_ff, fresh_in;
   logic                        silent_ff, silent_in;
   logic                        rollback_ff, rollback_in;
   logic                        res_acc_ff, res_acc_in;
   logic                        res_fnd_ff, res_fnd_in;
   logic                        pend_ok_ff, pend_ok_in;
   ptrf_pkg::slot_type          pend_ff, pend_in;
   logic [ptrf_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ptrf_pkg::rsp_type           rsp_ff, rsp_in;
   logic [ptrf_pkg::CSR_DATA_W-1:0] timeout_ff, timeout_in;
   logic [ptrf_pkg::CSR_DATA_W-1:0] reboot_ff, reboot_in;

   logic                        out_free;
   logic                        last_idx;
   logic [ptrf_pkg::TIME_W-1:0] age;
   logic                        hit;
   logic                        cap_hit;
   logic                        fresh_c;
   logic [ptrf_pkg::SLOT_W-1:0] tgt_c;
   logic [ptrf_pkg::TIME_W-1:0] eff_rx;
   logic [ptrf_pkg::SEQ_W-1:0]  eff_seq;
   logic                        hist_reset;
   logic                        accept;
   ptrf_pkg::slot_type          new_slot;

   // build a snapshot result word from a table entry
   function automatic ptrf_pkg::rsp_type entry_rsp(ptrf_pkg::slot_type s, logic is_last);
      ptrf_pkg::rsp_type r;
      r.accepted     = 1'b0;
      r.found        = 1'b0;
      r.entry_valid  = 1'b1;
      r.peer_addr    = s.addr;
      r.peer_seq     = s.seq;
      r.peer_accel   = s.accel;
      r.peer_rx_time = s.rx_time;
      r.peer_motion  = s.motion;
      r.last         = is_last;
      return r;
   endfunction

   // build a single-word result with only flags set
   function automatic ptrf_pkg::rsp_type flag_rsp(logic acc, logic fnd);
      ptrf_pkg::rsp_type r;
      r          = '0;
      r.accepted = acc;
      r.found    = fnd;
      r.last     = 1'b1;
      return r;
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign last_idx  = (idx_ff == ptrf_pkg::SLOT_W'(ptrf_pkg::NUM_SLOTS - 1));
   assign age       = item_ff.now - rd_slot.rx_time;
   assign hit       = rd_slot.used && (age <= timeout_ff);
   assign cap_hit   = (cnt_ff == ptrf_pkg::CNT_W'(ptrf_pkg::RESULT_CAP - 1));

   // control registers
   always_comb begin
      timeout_in = timeout_ff;
      reboot_in  = reboot_ff;
      if (csr_valid) begin
         unique case (ptrf_pkg::csr_type'(csr_index))
            ptrf_pkg::CSR_TIMEOUT: timeout_in = csr_wdata;
            ptrf_pkg::CSR_REBOOT:  reboot_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // update-path datapath: slot choice and history checks
   always_comb begin
      fresh_c    = !match_ok_ff;
      tgt_c      = match_ok_ff ? match_idx_ff : (free_ok_ff ? free_idx_ff : pick_ff);
      eff_rx     = fresh_c ? '0 : rd_slot.rx_time;
      hist_reset = fresh_ff || silent_ff || rollback_ff;
      eff_seq    = hist_reset ? '0 : rd_slot.seq;
      accept     = (item_ff.seq > eff_seq) || (eff_seq == '0);
      new_slot.used    = 1'b1;
      new_slot.addr    = item_ff.addr;
      new_slot.seq     = accept ? item_ff.seq : eff_seq;
      new_slot.accel   = accept ? item_ff.accel : rd_slot.accel;
      new_slot.rx_time = accept ? item_ff.now : rd_slot.rx_time;
      new_slot.motion  = hist_reset ? '0 : rd_slot.motion;
   end

   // sequencer: next state, table access and result loading
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      idx_in       = idx_ff;
      match_ok_in  = match_ok_ff;
      match_idx_in = match_idx_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      worst_in     = worst_ff;
      pick_in      = pick_ff;
      tgt_in       = tgt_ff;
      fresh_in     = fresh_ff;
      silent_in    = silent_ff;
      rollback_in  = rollback_ff;
      res_acc_in   = res_acc_ff;
      res_fnd_in   = res_fnd_ff;
      pend_ok_in   = pend_ok_ff;
      pend_in      = pend_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      head_pop     = 1'b0;
      rd_idx       = idx_ff;
      tbl_wr       = '0;

      unique case (state_ff)
         ptrf_pkg::ST_IDLE: begin
            if (head_valid) begin
               head_pop    = 1'b1;
               item_in     = head_item;
               idx_in      = '0;
               match_ok_in = 1'b0;
               free_ok_in  = 1'b0;
               worst_in    = '0;
               pick_in     = '0;
               pend_ok_in  = 1'b0;
               cnt_in      = '0;
               unique case (head_item.op)
                  ptrf_pkg::OP_UPDATE,
                  ptrf_pkg::OP_MOTION:   state_in = ptrf_pkg::ST_SCAN;
                  ptrf_pkg::OP_SNAPSHOT: state_in = ptrf_pkg::ST_SNAP;
                  ptrf_pkg::OP_CLEAR:    state_in = ptrf_pkg::ST_CLEAR;
                  default:               state_in = ptrf_pkg::ST_IDLE;
               endcase
            end
         end

         // one slot per cycle: match, first free, stalest
         ptrf_pkg::ST_SCAN: begin
            if (rd_slot.used && (rd_slot.addr == item_ff.addr) && !match_ok_ff) begin
               match_ok_in  = 1'b1;
               match_idx_in = idx_ff;
            end
            if (!rd_slot.used && !free_ok_ff) begin
               free_ok_in  = 1'b1;
               free_idx_in = idx_ff;
            end
            if (rd_slot.used && (age >= worst_ff)) begin
               worst_in = age;
               pick_in  = idx_ff;
            end
            if (last_idx) begin
               state_in = (item_ff.op == ptrf_pkg::OP_UPDATE) ?
                          ptrf_pkg::ST_EVAL : ptrf_pkg::ST_MOTION;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // silence and rollback checks on the chosen slot
         ptrf_pkg::ST_EVAL: begin
            rd_idx      = tgt_c;
            tgt_in      = tgt_c;
            fresh_in    = fresh_c;
            silent_in   = (item_ff.now - eff_rx) > timeout_ff;
            rollback_in = !fresh_c && (item_ff.seq < rd_slot.seq) &&
                          ((rd_slot.seq - item_ff.seq) > reboot_ff);
            state_in    = ptrf_pkg::ST_COMMIT;
         end

         // accept test and slot write
         ptrf_pkg::ST_COMMIT: begin
            rd_idx      = tgt_ff;
            tbl_wr.we   = 1'b1;
            tbl_wr.idx  = tgt_ff;
            tbl_wr.data = new_slot;
            res_acc_in  = accept;
            res_fnd_in  = 1'b0;
            state_in    = ptrf_pkg::ST_RESULT;
         end

         ptrf_pkg::ST_MOTION: begin
            rd_idx = match_idx_ff;
            if (match_ok_ff) begin
               tbl_wr.we          = 1'b1;
               tbl_wr.idx         = match_idx_ff;
               tbl_wr.data        = rd_slot;
               tbl_wr.data.motion = item_ff.motion;
            end
            res_acc_in = 1'b0;
            res_fnd_in = match_ok_ff;
            state_in   = ptrf_pkg::ST_RESULT;
         end

         ptrf_pkg::ST_CLEAR: begin
            tbl_wr.clr = 1'b1;
            res_acc_in = 1'b0;
            res_fnd_in = 1'b0;
            state_in   = ptrf_pkg::ST_RESULT;
         end

         ptrf_pkg::ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = flag_rsp(res_acc_ff, res_fnd_ff);
               state_in     = ptrf_pkg::ST_IDLE;
            end
         end

         // snapshot: one entry held back so the final one can carry last
         ptrf_pkg::ST_SNAP: begin
            if (!(hit && pend_ok_ff && !out_free)) begin
               if (hit) begin
                  if (pend_ok_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = entry_rsp(pend_ff, 1'b0);
                  end
                  pend_ok_in = 1'b1;
                  pend_in    = rd_slot;
                  cnt_in     = cnt_ff + 1'b1;
               end
               if (last_idx || (hit && cap_hit)) begin
                  state_in = ptrf_pkg::ST_SNAP_END;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         ptrf_pkg::ST_SNAP_END: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ok_ff ? entry_rsp(pend_ff, 1'b1) : flag_rsp(1'b0, 1'b0);
               state_in     = ptrf_pkg::ST_IDLE;
            end
         end

         default: state_in = ptrf_pkg::ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptrf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ok_ff   <= 1'b0;
         match_ok_ff  <= 1'b0;
         free_ok_ff   <= 1'b0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         timeout_ff   <= ptrf_pkg::TIMEOUT_RST;
         reboot_ff    <= ptrf_pkg::REBOOT_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ok_ff   <= pend_ok_in;
         match_ok_ff  <= match_ok_in;
         free_ok_ff   <= free_ok_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         timeout_ff   <= timeout_in;
         reboot_ff    <= reboot_in;
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      worst_ff     <= worst_in;
      pick_ff      <= pick_in;
      tgt_ff       <= tgt_in;
      fresh_ff     <= fresh_in;
      silent_ff    <= silent_in;
      rollback_ff  <= rollback_in;
      res_acc_ff   <= res_acc_in;
      res_fnd_ff   <= res_fnd_in;
      pend_ff      <= pend_in;
      rsp_ff       <= rsp_in;
   end

endmodule

// ===== hdl/peer_table_replay_filter_unit.sv =====
// top level of the peer table replay filter
// depends on ptrf_pkg, ptrf_front, ptrf_table, ptrf_back

// Peer table with sequence-number replay filter over 16 slots. A two-word
// queue takes requests while the back end walks the table one slot per
// cycle through a single read port, pausing a snapshot while the result
// side stalls. An update runs scan, check, write, result; a set-motion runs
// scan, write, result; a clear runs clear, result; a snapshot emits up to
// one fresh entry per cycle. Results leave through an output register, so
// a finished word can wait while the next request is already queued. Control
// register writes are taken in any cycle and should only be issued when idle.
module peer_table_replay_filter_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [ptrf_pkg::ACTION_W-1:0]         req_action,
   input  logic [ptrf_pkg::ADDR_W-1:0]           req_station_addr,
   input  logic [ptrf_pkg::SEQ_W-1:0]            req_seq_num,
   input  logic signed [ptrf_pkg::ACCEL_W-1:0]   req_accel_value,
   input  logic [ptrf_pkg::TIME_W-1:0]           req_now_time,
   input  logic [ptrf_pkg::MOTION_W-1:0]         req_motion_code,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_accepted,
   output logic                                  rsp_found,
   output logic                                  rsp_entry_valid,
   output logic [ptrf_pkg::ADDR_W-1:0]           rsp_peer_addr,
   output logic [ptrf_pkg::SEQ_W-1:0]            rsp_peer_seq,
   output logic signed [ptrf_pkg::ACCEL_W-1:0]   rsp_peer_accel,
   output logic [ptrf_pkg::TIME_W-1:0]           rsp_peer_rx_time,
   output logic [ptrf_pkg::MOTION_W-1:0]         rsp_peer_motion,
   output logic                                  rsp_last,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ptrf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ptrf_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   logic                           head_valid;
   ptrf_pkg::item_type             head_item;
   logic                           head_pop;
   logic [ptrf_pkg::SLOT_W-1:0]    rd_idx;
   ptrf_pkg::slot_type             rd_slot;
   ptrf_pkg::tbl_wr_type           tbl_wr;
   ptrf_pkg::rsp_type              rsp;

   // register writes never stall
   assign csr_ready = 1'b1;

   ptrf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_station_addr (req_station_addr),
      .req_seq_num      (req_seq_num),
      .req_accel_value  (req_accel_value),
      .req_now_time     (req_now_time),
      .req_motion_code  (req_motion_code),
      .head_valid       (head_valid),
      .head_item        (head_item),
      .head_pop         (head_pop)
   );

   ptrf_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (rd_idx),
      .rd_slot (rd_slot),
      .wr      (tbl_wr)
   );

   ptrf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop),
      .rd_idx     (rd_idx),
      .rd_slot    (rd_slot),
      .tbl_wr     (tbl_wr),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   // result fields
   assign rsp_accepted     = rsp.accepted;
   assign rsp_found        = rsp.found;
   assign rsp_entry_valid  = rsp.entry_valid;
   assign rsp_peer_addr    = rsp.peer_addr;
   assign rsp_peer_seq     = rsp.peer_seq;
   assign rsp_peer_accel   = rsp.peer_accel;
   assign rsp_peer_rx_time = rsp.peer_rx_time;
   assign rsp_peer_motion  = rsp.peer_motion;
   assign rsp_last         = rsp.last;

endmodule

// ===== dv/ptrf_checker.sv =====
// result checker for the peer table replay filter: keeps its own copy of the
// peer table, predicts the words of each accepted request and compares them
// depends on ptrf_pkg
module ptrf_checker
   import ptrf_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [ACTION_W-1:0]         req_action,
   input  logic [ADDR_W-1:0]           req_station_addr,
   input  logic [SEQ_W-1:0]            req_seq_num,
   input  logic signed [ACCEL_W-1:0]   req_accel_value,
   input  logic [TIME_W-1:0]           req_now_time,
   input  logic [MOTION_W-1:0]         req_motion_code,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic                        rsp_accepted,
   input  logic                        rsp_found,
   input  logic                        rsp_entry_valid,
   input  logic [ADDR_W-1:0]           rsp_peer_addr,
   input  logic [SEQ_W-1:0]            rsp_peer_seq,
   input  logic signed [ACCEL_W-1:0]   rsp_peer_accel,
   input  logic [TIME_W-1:0]           rsp_peer_rx_time,
   input  logic [MOTION_W-1:0]         rsp_peer_motion,
   input  logic                        rsp_last,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata,
   output int                          fail_count,
   output int                          pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow registers and peer table
   logic [TIME_W-1:0] stale_limit;
   logic [SEQ_W-1:0]  reboot_limit;
   slot_type          peer_tbl [NUM_SLOTS];
   rsp_type           expected_words [$];

   // first used slot holding this address, or -1
   function automatic int find_peer(logic [ADDR_W-1:0] addr);
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (peer_tbl[i].used && peer_tbl[i].addr == addr) return i;
      end
      return -1;
   endfunction

   // first free slot, else the stalest one with ties to the highest index
   function automatic int pick_victim(logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] age;
      logic [TIME_W-1:0] worst;
      int                pick;
      worst = '0;
      pick  = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (!peer_tbl[i].used) return i;
         age = now - peer_tbl[i].rx_time;
         if (age >= worst) begin
            worst = age;
            pick  = i;
         end
      end
      return pick;
   endfunction

   // apply one request to the table and queue the words it produces
   function automatic void predict_words(item_type w);
      rsp_type           r;
      int                idx;
      int                n;
      logic              new_peer;
      logic              silent;
      logic              rollback;
      logic [TIME_W-1:0] age;
      logic [SEQ_W-1:0]  back_step;
      r = '0;
      r.last = 1'b1;
      case (w.op)
         OP_UPDATE: begin
            new_peer = 1'b0;
            idx = find_peer(w.addr);
            if (idx < 0) begin
               idx = pick_victim(w.now);
               peer_tbl[idx] = '0;
               peer_tbl[idx].used = 1'b1;
               peer_tbl[idx].addr = w.addr;
               new_peer = 1'b1;
            end
            age = w.now - peer_tbl[idx].rx_time;
            silent = age > stale_limit;
            back_step = peer_tbl[idx].seq - w.seq;
            rollback = (w.seq < peer_tbl[idx].seq) && (back_step > reboot_limit);
            // history restarts on a new, silent or rebooted peer
            if (new_peer || silent || rollback) begin
               peer_tbl[idx].seq = '0;
               peer_tbl[idx].motion = '0;
            end
            if (w.seq > peer_tbl[idx].seq || peer_tbl[idx].seq == '0) begin
               peer_tbl[idx].seq = w.seq;
               peer_tbl[idx].accel = w.accel;
               peer_tbl[idx].rx_time = w.now;
               r.accepted = 1'b1;
            end
            expected_words.push_back(r);
         end
         OP_MOTION: begin
            idx = find_peer(w.addr);
            if (idx >= 0) begin
               peer_tbl[idx].motion = w.motion;
               r.found = 1'b1;
            end
            expected_words.push_back(r);
         end
         OP_CLEAR: begin
            foreach (peer_tbl[i]) peer_tbl[i] = '0;
            expected_words.push_back(r);
         end
         OP_SNAPSHOT: begin
            n = 0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               age = w.now - peer_tbl[i].rx_time;
               if (n < RESULT_CAP && peer_tbl[i].used && age <= stale_limit) begin
                  r = '0;
                  r.entry_valid  = 1'b1;
                  r.peer_addr    = peer_tbl[i].addr;
                  r.peer_seq     = peer_tbl[i].seq;
                  r.peer_accel   = peer_tbl[i].accel;
                  r.peer_rx_time = peer_tbl[i].rx_time;
                  r.peer_motion  = peer_tbl[i].motion;
                  expected_words.push_back(r);
                  n++;
               end
            end
            // empty snapshot gives one bare closing word
            if (n == 0) begin
               r = '0;
               r.last = 1'b1;
            end else begin
               r = expected_words.pop_back();
               r.last = 1'b1;
            end
            expected_words.push_back(r);
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // watch all three channels at each edge
   always @(posedge clock) begin
      item_type w;
      rsp_type  want;
      if (reset) begin
         stale_limit  = TIMEOUT_RST;
         reboot_limit = REBOOT_RST;
         foreach (peer_tbl[i]) peer_tbl[i] = '0;
         expected_words.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_type'(csr_index))
               CSR_TIMEOUT: stale_limit = csr_wdata;
               CSR_REBOOT:  reboot_limit = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            w.op     = op_type'(req_action);
            w.addr   = req_station_addr;
            w.seq    = req_seq_num;
            w.accel  = req_accel_value;
            w.now    = req_now_time;
            w.motion = req_motion_code;
            predict_words(w);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("result word arrived with nothing expected");
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("accepted", 64'(want.accepted), 64'(rsp_accepted));
               check_field("found", 64'(want.found), 64'(rsp_found));
               check_field("entry_valid", 64'(want.entry_valid), 64'(rsp_entry_valid));
               check_field("peer_addr", 64'(want.peer_addr), 64'(rsp_peer_addr));
               check_field("peer_seq", 64'(want.peer_seq), 64'(rsp_peer_seq));
               check_field("peer_accel", 64'(want.peer_accel), 64'(rsp_peer_accel));
               check_field("peer_rx_time", 64'(want.peer_rx_time), 64'(rsp_peer_rx_time));
               check_field("peer_motion", 64'(want.peer_motion), 64'(rsp_peer_motion));
               check_field("last", 64'(want.last), 64'(rsp_last));
            end
         end
      end
      pending_words = expected_words.size();
   end

endmodule

// ===== dv/peer_table_replay_filter_unit_tb.sv =====
// testbench top for the peer table replay filter: drives requests, register
// writes and result back-pressure, and reports the verdict
// depends on ptrf_pkg, ptrf_checker and the block under hdl
module peer_table_replay_filter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ptrf_pkg::*;

   localparam int POOL_SIZE = 24;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [ACTION_W-1:0]       req_action = '0;
   logic [ADDR_W-1:0]         req_station_addr = '0;
   logic [SEQ_W-1:0]          req_seq_num = '0;
   logic signed [ACCEL_W-1:0] req_accel_value = '0;
   logic [TIME_W-1:0]         req_now_time = '0;
   logic [MOTION_W-1:0]       req_motion_code = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_accepted;
   logic                      rsp_found;
   logic                      rsp_entry_valid;
   logic [ADDR_W-1:0]         rsp_peer_addr;
   logic [SEQ_W-1:0]          rsp_peer_seq;
   logic signed [ACCEL_W-1:0] rsp_peer_accel;
   logic [TIME_W-1:0]         rsp_peer_rx_time;
   logic [MOTION_W-1:0]       rsp_peer_motion;
   logic                      rsp_last;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;
   int                        fail_count;
   int                        pending_words;

   // traffic shaping state
   bit                        calm = 1'b0;
   logic [TIME_W-1:0]         clock_ms = '0;
   logic [ADDR_W-1:0]         pool_addr [POOL_SIZE];
   logic [SEQ_W-1:0]          pool_seq [POOL_SIZE];

   always #5 clock = ~clock;

   peer_table_replay_filter_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_station_addr (req_station_addr),
      .req_seq_num      (req_seq_num),
      .req_accel_value  (req_accel_value),
      .req_now_time     (req_now_time),
      .req_motion_code  (req_motion_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_accepted     (rsp_accepted),
      .rsp_found        (rsp_found),
      .rsp_entry_valid  (rsp_entry_valid),
      .rsp_peer_addr    (rsp_peer_addr),
      .rsp_peer_seq     (rsp_peer_seq),
      .rsp_peer_accel   (rsp_peer_accel),
      .rsp_peer_rx_time (rsp_peer_rx_time),
      .rsp_peer_motion  (rsp_peer_motion),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   ptrf_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_station_addr (req_station_addr),
      .req_seq_num      (req_seq_num),
      .req_accel_value  (req_accel_value),
      .req_now_time     (req_now_time),
      .req_motion_code  (req_motion_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_accepted     (rsp_accepted),
      .rsp_found        (rsp_found),
      .rsp_entry_valid  (rsp_entry_valid),
      .rsp_peer_addr    (rsp_peer_addr),
      .rsp_peer_seq     (rsp_peer_seq),
      .rsp_peer_accel   (rsp_peer_accel),
      .rsp_peer_rx_time (rsp_peer_rx_time),
      .rsp_peer_motion  (rsp_peer_motion),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending_words    (pending_words)
   );

   function automatic logic [ADDR_W-1:0] rand_addr();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[ADDR_W-1:0];
   endfunction

   // next sequence number for a pool peer: mostly rising, some replays and reboots
   function automatic logic [SEQ_W-1:0] next_seq(int pick);
      logic [SEQ_W-1:0] s;
      int               r;
      s = pool_seq[pick];
      r = $urandom_range(0, 19);
      if (r < 12) s = s + $urandom_range(1, 5);
      else if (r < 14) s = s;
      else if (r < 16) s = s - $urandom_range(1, 30);
      else if (r == 16) s = s - $urandom_range(31, 100000);
      else if (r == 17) s = '0;
      else if (r == 18) s = $urandom;
      else s = s + $urandom_range(1000, 100000);
      pool_seq[pick] = s;
      return s;
   endfunction

   // present one request word and hold it until taken
   task automatic drive_word(op_type op, logic [ADDR_W-1:0] addr, logic [SEQ_W-1:0] seq,
                             logic signed [ACCEL_W-1:0] accel, logic [TIME_W-1:0] now,
                             logic [MOTION_W-1:0] motion);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= op;
      req_station_addr <= addr;
      req_seq_num      <= seq;
      req_accel_value  <= accel;
      req_now_time     <= now;
      req_motion_code  <= motion;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop requesting and wait for every expected word
   task automatic drain_words();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
   endtask

   // write both limits back to back
   task automatic program_limits(logic [CSR_DATA_W-1:0] timeout, logic [CSR_DATA_W-1:0] gap);
      csr_valid <= 1'b1;
      csr_index <= CSR_TIMEOUT;
      csr_wdata <= timeout;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_REBOOT;
      csr_wdata <= gap;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // edge cases with the reset limits
   task automatic run_directed();
      drive_word(OP_SNAPSHOT, '0, '0, '0, 32'd10, '0);
      drive_word(OP_MOTION, 48'h1234_5678_9abc, '0, '0, 32'd10, 3'd5);
      drive_word(OP_UPDATE, '0, '0, 16'sh8000, '0, '0);
      drive_word(OP_UPDATE, '1, '1, 16'sh7fff, '1, '1);
      // replay, small step back, then a reboot-sized step back
      drive_word(OP_UPDATE, '1, '1, 16'sh1234, '1, '0);
      drive_word(OP_UPDATE, '1, 32'hffff_fff0, 16'sh0001, '1, '0);
      drive_word(OP_UPDATE, '1, 32'hffff_f000, 16'sh0002, '1, '0);
      drive_word(OP_MOTION, '1, '0, '0, '1, 3'd7);
      drive_word(OP_CLEAR, '0, '0, '0, '0, '0);
      // fill every slot at one time, so the next new peer hits an age tie
      for (int i = 0; i < NUM_SLOTS; i++) begin
         drive_word(OP_UPDATE, 48'h5000 + i, i + 1, ACCEL_W'(i), 32'd500, '0);
      end
      drive_word(OP_UPDATE, 48'h6000, 32'd7, 16'sd9, 32'd600, '0);
      drive_word(OP_SNAPSHOT, '0, '0, '0, 32'd700, '0);
      drive_word(OP_UPDATE, 48'h5000, 32'd9, -16'sd3, 32'd5000, '0);
   endtask

   // mostly well-formed peer traffic over a small address pool, some noise
   task automatic stream_traffic(int count);
      int r;
      int pick;
      for (int k = 0; k < count; k++) begin
         if (k % 20 == 0) calm = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 9);
         if (r >= 3 && r < 7) clock_ms += $urandom_range(1, 20);
         else if (r >= 7 && r < 9) clock_ms += $urandom_range(0, 3000);
         else if (r == 9) clock_ms += $urandom;
         pick = $urandom_range(0, POOL_SIZE - 1);
         r = $urandom_range(0, 99);
         if (r < 58) begin
            drive_word(OP_UPDATE, pool_addr[pick], next_seq(pick), ACCEL_W'($urandom),
                       clock_ms, MOTION_W'($urandom_range(0, 7)));
         end else if (r < 72) begin
            drive_word(OP_MOTION, ($urandom_range(0, 4) == 0) ? rand_addr() : pool_addr[pick],
                       $urandom, ACCEL_W'($urandom), clock_ms,
                       MOTION_W'($urandom_range(0, 7)));
         end else if (r < 86) begin
            drive_word(OP_SNAPSHOT, rand_addr(), $urandom, ACCEL_W'($urandom), clock_ms,
                       MOTION_W'($urandom_range(0, 7)));
         end else if (r < 89) begin
            drive_word(OP_CLEAR, rand_addr(), $urandom, ACCEL_W'($urandom), clock_ms,
                       MOTION_W'($urandom_range(0, 7)));
         end else begin
            drive_word(op_type'($urandom_range(0, 3)), rand_addr(), $urandom,
                       ACCEL_W'($urandom), $urandom, MOTION_W'($urandom_range(0, 7)));
         end
      end
   endtask

   // result side back-pressure
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 11);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // stimulus and verdict
   initial begin
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_addr[i] = rand_addr();
         pool_seq[i]  = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 100);
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      drain_words();
      program_limits(32'd0, 32'd0);
      clock_ms = $urandom;
      stream_traffic(70);
      drain_words();
      program_limits('1, '1);
      stream_traffic(110);
      drain_words();
      // time wraps early in this phase
      program_limits(32'd300, 32'd20);
      clock_ms = 32'hffff_e000;
      stream_traffic(140);
      drain_words();
      program_limits($urandom_range(50, 5000), $urandom_range(0, 2000));
      stream_traffic(130);
      drain_words();
      repeat (NUM_SLOTS + 8) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== peer_table_replay_filter_unit.f =====
hdl/ptrf_pkg.sv
hdl/ptrf_front.sv
hdl/ptrf_table.sv
hdl/ptrf_back.sv
hdl/peer_table_replay_filter_unit.sv
dv/ptrf_checker.sv
dv/peer_table_replay_filter_unit_tb.sv
